/* design/contiguous_frame_allocator_core_assert.svh */
// Assertion macros used by the checker file.
`ifndef CONTIGUOUS_FRAME_ALLOCATOR_CORE_ASSERT_SVH
`define CONTIGUOUS_FRAME_ALLOCATOR_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define CFA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock edge.
`define CFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* design/cfa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package cfa_pkg;

    localparam int CNT_W   = 11;
    localparam int START_W = 10;
    localparam int FRAME_W = 10;
    localparam int ADDR_W  = 32;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 1;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 56;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_IN_USE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS  = 1'b1;

    localparam logic [CNT_W-1:0]  FRAMES_RESET = 11'd1024;
    localparam logic [ADDR_W-1:0] BASE_RESET   = 32'd0;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_HOLD        = 4'd0;
    localparam logic [OP_W-1:0] OP_CLEAR       = 4'd1;
    localparam logic [OP_W-1:0] OP_ALLOC_BEGIN = 4'd2;
    localparam logic [OP_W-1:0] OP_FREE_BEGIN  = 4'd3;
    localparam logic [OP_W-1:0] OP_SCAN        = 4'd4;
    localparam logic [OP_W-1:0] OP_FOUND       = 4'd5;
    localparam logic [OP_W-1:0] OP_FAIL        = 4'd6;
    localparam logic [OP_W-1:0] OP_WRITE       = 4'd7;
    localparam logic [OP_W-1:0] OP_ADDR        = 4'd8;
    localparam logic [OP_W-1:0] OP_FREE_STEP   = 4'd9;
    localparam logic [OP_W-1:0] OP_FREE_END    = 4'd10;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            load_out;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic scan_end;
        logic run_hit;
        logic wr_last;
        logic free_stop;
    } t_status;

endpackage

`default_nettype wire

/* design/cfa_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module cfa_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire logic            i_in_func,
    input  wire logic            i_out_ready,
    output logic                 o_out_valid,
    output cfa_pkg::t_cmd        o_cmd,
    input  wire cfa_pkg::t_status i_status
);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_A_SCAN = 3'd2;
    localparam logic [2:0] ST_A_WR   = 3'd3;
    localparam logic [2:0] ST_A_ADDR = 3'd4;
    localparam logic [2:0] ST_F_SCAN = 3'd5;
    localparam logic [2:0] ST_DONE   = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;

    always_comb begin
        n_state        = r_state;
        o_cmd.op       = cfa_pkg::OP_HOLD;
        o_cmd.load_out = 1'b0;
        o_in_ready     = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.op = cfa_pkg::OP_CLEAR;
                if (i_status.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_func == cfa_pkg::FUNC_FREE) begin
                        o_cmd.op = cfa_pkg::OP_FREE_BEGIN;
                        n_state  = ST_F_SCAN;
                    end else begin
                        o_cmd.op = cfa_pkg::OP_ALLOC_BEGIN;
                        n_state  = ST_A_SCAN;
                    end
                end
            end
            ST_A_SCAN: begin
                priority if (i_status.scan_end) begin
                    o_cmd.op = cfa_pkg::OP_FAIL;
                    n_state  = ST_DONE;
                end else if (i_status.run_hit) begin
                    o_cmd.op = cfa_pkg::OP_FOUND;
                    n_state  = ST_A_WR;
                end else begin
                    o_cmd.op = cfa_pkg::OP_SCAN;
                end
            end
            ST_A_WR: begin
                o_cmd.op = cfa_pkg::OP_WRITE;
                if (i_status.wr_last) begin
                    n_state = ST_A_ADDR;
                end
            end
            ST_A_ADDR: begin
                o_cmd.op = cfa_pkg::OP_ADDR;
                n_state  = ST_DONE;
            end
            ST_F_SCAN: begin
                if (i_status.free_stop) begin
                    o_cmd.op = cfa_pkg::OP_FREE_END;
                    n_state  = ST_DONE;
                end else begin
                    o_cmd.op = cfa_pkg::OP_FREE_STEP;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

/* design/cfa_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module cfa_datapath #(
    parameter int MAP_FRAMES = 1024,
    parameter int PAGE_BYTES = 4096
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire cfa_pkg::t_cmd                   i_cmd,
    output cfa_pkg::t_status                     o_status,
    input  wire logic                            i_cfg_we,
    input  wire logic [cfa_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [cfa_pkg::CFG_W-1:0]       i_cfg_data,
    input  wire logic [cfa_pkg::CNT_W-1:0]       i_page_count,
    input  wire logic [cfa_pkg::START_W-1:0]     i_start_frame,
    output logic                                 o_ok,
    output logic [cfa_pkg::FRAME_W-1:0]          o_frame_found,
    output logic [cfa_pkg::ADDR_W-1:0]           o_phys_address,
    output logic [cfa_pkg::CNT_W-1:0]            o_freed_count
);

    localparam int AW  = (MAP_FRAMES > 1) ? $clog2(MAP_FRAMES) : 1;
    localparam int IW0 = $clog2(MAP_FRAMES + 1);
    localparam int IW  = (IW0 > cfa_pkg::CNT_W) ? IW0 : cfa_pkg::CNT_W;
    localparam int CW  = cfa_pkg::CNT_W;
    localparam logic [IW-1:0] MAP_I      = IW'(MAP_FRAMES);
    localparam logic [IW-1:0] MAP_LAST_I = IW'(MAP_FRAMES - 1);
    localparam logic [cfa_pkg::ADDR_W-1:0] PAGE_C = cfa_pkg::ADDR_W'(PAGE_BYTES);

    logic [CW-1:0] mem [MAP_FRAMES];
    logic [CW-1:0] r_rdata;

    logic [IW-1:0] r_idx,   n_idx;
    logic [IW-1:0] r_limit, n_limit;
    logic [IW-1:0] r_first, n_first;
    logic [CW-1:0] r_run,   n_run;
    logic [CW-1:0] r_cnt,   n_cnt;
    logic [CW-1:0] r_k,     n_k;
    logic [CW-1:0] r_cleared, n_cleared;
    logic [cfa_pkg::ADDR_W-1:0] r_prod;

    logic [CW-1:0]              r_frames;
    logic [cfa_pkg::ADDR_W-1:0] r_base;

    logic                        r_res_ok,    n_res_ok;
    logic [cfa_pkg::FRAME_W-1:0] r_res_frame, n_res_frame;
    logic [cfa_pkg::ADDR_W-1:0]  r_res_addr,  n_res_addr;
    logic [CW-1:0]               r_res_freed, n_res_freed;

    logic                        r_out_ok;
    logic [cfa_pkg::FRAME_W-1:0] r_out_frame;
    logic [cfa_pkg::ADDR_W-1:0]  r_out_addr;
    logic [CW-1:0]               r_out_freed;

    logic          wr_en;
    logic [CW-1:0] wr_data;
    logic [IW-1:0] frames_ext;

    assign frames_ext = IW'(r_frames);

    always_comb begin
        o_status.clr_last  = (r_idx == MAP_LAST_I);
        o_status.scan_end  = (r_idx >= r_limit) || (r_cnt == '0);
        o_status.run_hit   = (r_rdata == '0) &&
                             (({1'b0, r_run} + (CW+1)'(1)) == {1'b0, r_cnt});
        o_status.wr_last   = (r_k == r_cnt);
        o_status.free_stop = (r_idx >= MAP_I) ||
                             ({1'b0, r_rdata} != ({1'b0, r_cleared} + (CW+1)'(1)));
    end

    always_comb begin
        n_idx       = r_idx;
        n_limit     = r_limit;
        n_first     = r_first;
        n_run       = r_run;
        n_cnt       = r_cnt;
        n_k         = r_k;
        n_cleared   = r_cleared;
        n_res_ok    = r_res_ok;
        n_res_frame = r_res_frame;
        n_res_addr  = r_res_addr;
        n_res_freed = r_res_freed;
        wr_en       = 1'b0;
        wr_data     = '0;
        unique case (i_cmd.op)
            cfa_pkg::OP_HOLD: begin
            end
            cfa_pkg::OP_CLEAR: begin
                wr_en = 1'b1;
                n_idx = r_idx + IW'(1);
            end
            cfa_pkg::OP_ALLOC_BEGIN: begin
                n_idx   = '0;
                n_run   = '0;
                n_cnt   = i_page_count;
                n_limit = (frames_ext > MAP_I) ? MAP_I : frames_ext;
            end
            cfa_pkg::OP_FREE_BEGIN: begin
                n_idx     = IW'(i_start_frame);
                n_cleared = '0;
            end
            cfa_pkg::OP_SCAN: begin
                n_idx = r_idx + IW'(1);
                n_run = (r_rdata == '0) ? r_run + CW'(1) : '0;
            end
            cfa_pkg::OP_FOUND: begin
                n_first = r_idx + IW'(1) - IW'(r_cnt);
                n_idx   = r_idx + IW'(1) - IW'(r_cnt);
                n_k     = CW'(1);
            end
            cfa_pkg::OP_FAIL: begin
                n_res_ok    = 1'b0;
                n_res_frame = '0;
                n_res_addr  = '0;
                n_res_freed = '0;
            end
            cfa_pkg::OP_WRITE: begin
                wr_en   = 1'b1;
                wr_data = r_k;
                n_idx   = r_idx + IW'(1);
                n_k     = r_k + CW'(1);
            end
            cfa_pkg::OP_ADDR: begin
                n_res_ok    = 1'b1;
                n_res_frame = cfa_pkg::FRAME_W'(r_first);
                n_res_addr  = r_base + r_prod;
                n_res_freed = '0;
            end
            cfa_pkg::OP_FREE_STEP: begin
                wr_en     = 1'b1;
                n_idx     = r_idx + IW'(1);
                n_cleared = r_cleared + CW'(1);
            end
            cfa_pkg::OP_FREE_END: begin
                n_res_ok    = 1'b1;
                n_res_frame = '0;
                n_res_addr  = '0;
                n_res_freed = r_cleared;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_idx[AW-1:0]] <= wr_data;
        end
        r_rdata <= mem[n_idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_frames <= cfa_pkg::FRAMES_RESET;
            r_base   <= cfa_pkg::BASE_RESET;
        end else begin
            r_idx <= n_idx;
            if (i_cfg_we && i_cfg_idx == cfa_pkg::CFG_FRAMES_IN_USE) begin
                r_frames <= i_cfg_data[CW-1:0];
            end
            if (i_cfg_we && i_cfg_idx == cfa_pkg::CFG_BASE_ADDRESS) begin
                r_base <= i_cfg_data[cfa_pkg::ADDR_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_limit     <= n_limit;
        r_first     <= n_first;
        r_run       <= n_run;
        r_cnt       <= n_cnt;
        r_k         <= n_k;
        r_cleared   <= n_cleared;
        r_prod      <= cfa_pkg::ADDR_W'(r_first) * PAGE_C;
        r_res_ok    <= n_res_ok;
        r_res_frame <= n_res_frame;
        r_res_addr  <= n_res_addr;
        r_res_freed <= n_res_freed;
        if (i_cmd.load_out) begin
            r_out_ok    <= r_res_ok;
            r_out_frame <= r_res_frame;
            r_out_addr  <= r_res_addr;
            r_out_freed <= r_res_freed;
        end
    end

    assign o_ok           = r_out_ok;
    assign o_frame_found  = r_out_frame;
    assign o_phys_address = r_out_addr;
    assign o_freed_count  = r_out_freed;

endmodule

`default_nettype wire

/* design/contiguous_frame_allocator_core.sv */
// First-fit contiguous frame allocator. After reset the frame map is cleared in a pass
// over all MAP_FRAMES frames during which no request is taken; configuration writes are
// taken at any time the block is idle. One request is worked at a time over one write
// port and one read port of the frame map. An allocate walks the map one frame per cycle:
// it scans up to limit = min(frames_in_use, MAP_FRAMES) frames for a free run of
// page_count frames, fails for a page count of zero or when no run is found, else
// writes the run and forms its address. A free clears frames from start_frame on while
// each holds its 1-based place in the run. The result sits in an output register, so
// the next request is accepted while it waits to be taken.
`timescale 1ns / 1ps
`default_nettype none

module contiguous_frame_allocator_core #(
    parameter int MAP_FRAMES = 1024,
    parameter int PAGE_BYTES = 4096
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [cfa_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [cfa_pkg::CFG_W-1:0]          i_cfg_data,
    input  wire logic                               i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // page_count[10:0], start_frame[20:11], zero pad
    input  wire logic [cfa_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // func
    input  wire logic                               i_s_axis_tuser,
    output logic                                    o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    // ok[0], frame_found[10:1], phys_address[42:11], freed_count[53:43], zero pad
    output logic [cfa_pkg::OUT_TDATA_W-1:0]         o_m_axis_tdata
);

    cfa_pkg::t_cmd    cmd;
    cfa_pkg::t_status status;

    logic                         ok;
    logic [cfa_pkg::FRAME_W-1:0]  frame_found;
    logic [cfa_pkg::ADDR_W-1:0]   phys_address;
    logic [cfa_pkg::CNT_W-1:0]    freed_count;

    cfa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_in_func   (i_s_axis_tuser),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    cfa_datapath #(
        .MAP_FRAMES (MAP_FRAMES),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_page_count   (i_s_axis_tdata[10:0]),
        .i_start_frame  (i_s_axis_tdata[20:11]),
        .o_ok           (ok),
        .o_frame_found  (frame_found),
        .o_phys_address (phys_address),
        .o_freed_count  (freed_count)
    );

    assign o_m_axis_tdata = {2'b00, freed_count, phys_address, frame_found, ok};

endmodule

`default_nettype wire

/* design/cfa_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "contiguous_frame_allocator_core_assert.svh"

module cfa_checker (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               i_s_axis_tvalid,
    input wire logic                               o_s_axis_tready,
    input wire logic                               i_m_axis_tready,
    input wire logic                               o_m_axis_tvalid,
    input wire logic [cfa_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata
);

    `CFA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid)
    `CFA_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready)
    `CFA_ASSERT_NOW(a_fail_zero, i_clk, i_rst_n, o_m_axis_tvalid && !o_m_axis_tdata[0], o_m_axis_tdata[55:1] == '0)
    `CFA_ASSERT_NOW(a_free_shape, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tdata[53:43] != '0, o_m_axis_tdata[0] && o_m_axis_tdata[42:1] == '0)

endmodule

bind contiguous_frame_allocator_core cfa_checker u_cfa_checker (.*);

`default_nettype wire
